@@ rtl/greedy_cheapest_edge_path_search_macros.svh @@
// assertion helpers shared by the rtl
`ifndef GREEDY_CHEAPEST_EDGE_PATH_SEARCH_MACROS_SVH
`define GREEDY_CHEAPEST_EDGE_PATH_SEARCH_MACROS_SVH
// property checked on every clock edge outside reset
`define GCEP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// condition that implies a property in the same cycle
`define GCEP_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`endif

@@ rtl/gcep_pkg.sv @@
package gcep_pkg;

    localparam int MAX_EDGES = 256;
    localparam int MAX_PATH  = 64;
    localparam int EW = $clog2(MAX_EDGES);
    localparam int PW = $clog2(MAX_PATH);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNREACHABLE = 3'd1;
    localparam logic [2:0] ST_NO_PATH     = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    localparam logic REG_START  = 1'b0;
    localparam logic REG_FINISH = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  edge_from;
        logic [7:0]  edge_to;
        logic [15:0] edge_weight;
    } request_t;

    typedef struct packed {
        logic [7:0] path_vertex;
        logic       path_last;
        logic [2:0] status;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // write request edge at edge_count
        logic clear;
        logic run_init;   // stack <= start, depth 1
        logic scan_init;  // begin scan of top vertex
        logic scan_step;  // read next edge entry
        logic push;       // mark best used, push its target
        logic mark;       // mark best used without a push
        logic pop;
        logic out_init;
        logic out_step;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic table_full;
        logic self_loop;
        logic start_eq_finish;
        logic finish_seen;
        logic top_is_finish;
        logic scan_done;
        logic found;
        logic stack_full;
        logic depth_one;
        logic out_last;
    } stat_t;

endpackage

@@ rtl/gcep_datapath.sv @@
`include "greedy_cheapest_edge_path_search_macros.svh"
module gcep_datapath import gcep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_t      ctrl,
    input  request_t   req,
    input  logic [7:0] start_vertex,
    input  logic [7:0] finish_vertex,
    output stat_t      stat,
    output logic [7:0] out_vertex
);

    logic [7:0]  src_mem  [MAX_EDGES];
    logic [7:0]  tgt_mem  [MAX_EDGES];
    logic [15:0] cost_mem [MAX_EDGES];
    logic [MAX_EDGES-1:0] used_reg;
    logic [7:0]  stack_mem [MAX_PATH];

    logic [EW:0] count_reg;
    logic        seen_reg;
    logic [PW:0] depth_reg;
    logic [7:0]  top_reg;
    logic [EW:0] scan_reg;     // index being read
    logic        rd_valid_reg; // read data belongs to scan_reg-1
    logic [EW-1:0] rd_idx_reg;
    logic [7:0]  rd_src_reg;
    logic [7:0]  rd_tgt_reg;
    logic [15:0] rd_cost_reg;
    logic        best_ok_reg;
    logic [EW-1:0] best_idx_reg;
    logic [15:0] best_cost_reg;
    logic [7:0]  best_tgt_reg;
    logic [PW:0] out_idx_reg;
    logic [7:0]  out_data_reg;
    logic [7:0]  pop_rd_reg;

    // edge table: write on load, read one entry per cycle during scan
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            src_mem[count_reg[EW-1:0]]  <= req.edge_from;
            tgt_mem[count_reg[EW-1:0]]  <= req.edge_to;
            cost_mem[count_reg[EW-1:0]] <= req.edge_weight;
        end
        rd_src_reg  <= src_mem[scan_reg[EW-1:0]];
        rd_tgt_reg  <= tgt_mem[scan_reg[EW-1:0]];
        rd_cost_reg <= cost_mem[scan_reg[EW-1:0]];
        rd_idx_reg  <= scan_reg[EW-1:0];
    end

    // path stack
    always_ff @(posedge clk)
    begin
        if (ctrl.run_init)
            stack_mem[0] <= start_vertex;
        else if (ctrl.push)
            stack_mem[depth_reg[PW-1:0]] <= best_tgt_reg;
        out_data_reg <= stack_mem[out_idx_reg[PW-1:0]];
        pop_rd_reg   <= stack_mem[depth_reg[PW-1:0] - PW'(2)];
    end

    logic cand;
    assign cand = rd_valid_reg && rd_src_reg == top_reg && !used_reg[rd_idx_reg]
                  && (!best_ok_reg || rd_cost_reg < best_cost_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            count_reg    <= '0;
            seen_reg     <= 1'b0;
            depth_reg    <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            best_ok_reg  <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                used_reg  <= '0;
                count_reg <= '0;
                seen_reg  <= 1'b0;
                depth_reg <= '0;
            end
            if (ctrl.load)
            begin
                used_reg[count_reg[EW-1:0]] <= 1'b0;
                count_reg <= count_reg + 1'b1;
                if (req.edge_to == finish_vertex)
                    seen_reg <= 1'b1;
            end
            if (ctrl.run_init)
                depth_reg <= (PW+1)'(1);
            if (ctrl.scan_init)
            begin
                scan_reg     <= '0;
                rd_valid_reg <= 1'b0;
                best_ok_reg  <= 1'b0;
            end
            if (ctrl.scan_step)
            begin
                if (scan_reg < count_reg)
                    scan_reg <= scan_reg + 1'b1;
                rd_valid_reg <= scan_reg < count_reg;
                if (cand)
                begin
                    best_ok_reg <= 1'b1;
                    best_idx_reg  <= rd_idx_reg;
                    best_cost_reg <= rd_cost_reg;
                    best_tgt_reg  <= rd_tgt_reg;
                end
            end
            if (ctrl.push || ctrl.mark)
                used_reg[best_idx_reg] <= 1'b1;
            if (ctrl.push)
                depth_reg <= depth_reg + 1'b1;
            if (ctrl.pop)
                depth_reg <= depth_reg - 1'b1;
            if (ctrl.out_init)
                out_idx_reg <= '0;
            if (ctrl.out_step)
                out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    // top of stack kept in a register, updated on push, pop and run
    always_ff @(posedge clk)
    begin
        if (ctrl.run_init)
            top_reg <= start_vertex;
        else if (ctrl.push)
            top_reg <= best_tgt_reg;
        else if (ctrl.pop)
            top_reg <= pop_rd_reg;
    end

    assign stat.table_full      = count_reg >= (EW+1)'(MAX_EDGES);
    assign stat.self_loop       = req.edge_from == req.edge_to;
    assign stat.start_eq_finish = start_vertex == finish_vertex;
    assign stat.finish_seen     = seen_reg;
    assign stat.top_is_finish   = top_reg == finish_vertex;
    assign stat.scan_done       = !rd_valid_reg && scan_reg >= count_reg;
    assign stat.found           = best_ok_reg;
    assign stat.stack_full      = depth_reg >= (PW+1)'(MAX_PATH);
    assign stat.depth_one       = depth_reg == (PW+1)'(1);
    assign stat.out_last        = out_idx_reg == depth_reg;
    assign out_vertex           = out_data_reg;

    `GCEP_ASSERT(a_depth_bound, depth_reg <= (PW+1)'(MAX_PATH), "stack depth over limit")
    `GCEP_ASSERT(a_count_bound, count_reg <= (EW+1)'(MAX_EDGES), "edge count over limit")
    `GCEP_ASSERT(a_push_pop, !(ctrl.push && ctrl.pop), "push and pop together")

endmodule

@@ rtl/gcep_ctrl.sv @@
`include "greedy_cheapest_edge_path_search_macros.svh"
module gcep_ctrl import gcep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  request_t   req,
    input  stat_t      stat,
    input  logic [7:0] start_vertex,
    input  logic [7:0] out_vertex,
    output ctrl_t      ctrl,
    output logic       busy,
    output logic       done,
    output result_t    result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_POPW  = 3'd3;
    localparam logic [2:0] S_OUTR  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;
    result_t    res_reg, res_next;

    logic go;
    assign go = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    priority if (req.command == CMD_LOAD)
                    begin
                        if (!stat.self_loop)
                        begin
                            if (stat.table_full)
                            begin
                                done_next = 1'b1;
                                res_next  = '{8'd0, 1'b1, ST_TABLE_FULL};
                            end
                            else
                                ctrl.load = 1'b1;
                        end
                    end
                    else if (req.command == CMD_CLEAR)
                        ctrl.clear = 1'b1;
                    else if (req.command == CMD_RUN)
                    begin
                        if (stat.start_eq_finish)
                        begin
                            done_next = 1'b1;
                            res_next  = '{start_vertex, 1'b1, ST_OK};
                        end
                        else if (!stat.finish_seen)
                        begin
                            done_next = 1'b1;
                            res_next  = '{8'd0, 1'b1, ST_UNREACHABLE};
                        end
                        else
                        begin
                            ctrl.run_init = 1'b1;
                            state_next    = S_CHECK;
                        end
                    end
                    else
                    begin
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.top_is_finish)
                begin
                    ctrl.out_init = 1'b1;
                    state_next    = S_OUTR;
                end
                else
                begin
                    ctrl.scan_init = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    ctrl.scan_step = 1'b0;
                    if (stat.found)
                    begin
                        if (stat.stack_full)
                        begin
                            ctrl.mark  = 1'b1;
                            done_next  = 1'b1;
                            res_next   = '{8'd0, 1'b1, ST_OVERFLOW};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctrl.push  = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    else if (stat.depth_one)
                    begin
                        done_next  = 1'b1;
                        res_next   = '{8'd0, 1'b1, ST_NO_PATH};
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                // stack read of new top is ready
                ctrl.pop       = 1'b1;
                state_next     = S_CHECK;
            end
            S_OUTR:
            begin
                ctrl.out_step = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                res_next  = '{out_vertex, stat.out_last, ST_OK};
                if (stat.out_last)
                    state_next = S_IDLE;
                else
                    state_next = S_OUTR;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // the overflow case also marks the used edge, as the walk does
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = state_reg != S_IDLE || done_reg;
    assign done   = done_reg;
    assign result = res_reg;

    `GCEP_ASSERT_IMPLY(a_last_idle, done_reg && res_reg.path_last, state_reg == S_IDLE,
        "last result while walking")
    `GCEP_ASSERT_IMPLY(a_no_go_busy, state_reg != S_IDLE, !go, "request taken while busy")
    `GCEP_ASSERT(a_pop_check, state_reg == S_POPW |=> state_reg == S_CHECK,
        "pop not followed by check")

endmodule

@@ rtl/greedy_cheapest_edge_path_search.sv @@
// load, clear: no result but ST_TABLE_FULL; quick status done in the cycle after start
// run: each walk step is a check plus an edge table scan, a backtrack adds a pop state
// path output: done high for one cycle per vertex, last marked by path_last
// throughput: loads and clears every cycle, busy held through each done; no result stall
// reset: asynchronous active low, clears control, config, edge count and visit marks
module greedy_cheapest_edge_path_search import gcep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  request_t    request,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] start_vertex_reg;
    logic [7:0] finish_vertex_reg;
    ctrl_t      ctrl;
    stat_t      stat;
    logic [7:0] out_vertex;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_vertex_reg  <= '0;
            finish_vertex_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_START)
                start_vertex_reg <= cfg_data;
            else
                finish_vertex_reg <= cfg_data;
        end
    end

    gcep_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .req           (request),
        .start_vertex  (start_vertex_reg),
        .finish_vertex (finish_vertex_reg),
        .stat          (stat),
        .out_vertex    (out_vertex)
    );

    gcep_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (request),
        .stat         (stat),
        .start_vertex (start_vertex_reg),
        .out_vertex   (out_vertex),
        .ctrl         (ctrl),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

endmodule

@@ dv/tb.sv @@
module tb;
    import gcep_pkg::*;

    localparam int STALL_LIMIT = 300000;

    logic       clk;
    logic       rst_n;
    logic       start;
    request_t   request;
    logic       busy;
    logic       done;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    greedy_cheapest_edge_path_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // shadow of the edge table and search registers
    logic [7:0]  walk_start;
    logic [7:0]  walk_finish;
    logic [7:0]  edge_src [MAX_EDGES];
    logic [7:0]  edge_dst [MAX_EDGES];
    logic [15:0] edge_wt [MAX_EDGES];
    logic        edge_taken [MAX_EDGES];
    int          edge_total;
    logic        finish_loaded;

    result_t expected_path[$];
    int      mismatches;
    int      requests_sent;
    int      results_seen;
    int      runs_sent;
    int      stall_cycles;
    bit      quiet;

    function automatic void expect_result(result_t r);
        expected_path = {expected_path, r};
    endfunction

    function automatic void push_status(logic [2:0] code);
        expect_result(result_t'{8'd0, 1'b1, code});
    endfunction

    function automatic void predict_walk();
        logic [7:0] trail [MAX_PATH];
        int depth;
        int best;
        logic [7:0] cur;
        if (walk_start == walk_finish)
        begin
            expect_result(result_t'{walk_start, 1'b1, ST_OK});
            return;
        end
        if (!finish_loaded)
        begin
            push_status(ST_UNREACHABLE);
            return;
        end
        depth = 1;
        trail[0] = walk_start;
        forever
        begin
            cur = trail[depth-1];
            if (cur == walk_finish)
                break;
            best = -1;
            for (int i = 0; i < edge_total; i++)
                if (edge_src[i] == cur && !edge_taken[i] &&
                    (best < 0 || edge_wt[i] < edge_wt[best]))
                    best = i;
            if (best >= 0)
            begin
                edge_taken[best] = 1'b1;
                if (depth >= MAX_PATH)
                begin
                    push_status(ST_OVERFLOW);
                    return;
                end
                trail[depth] = edge_dst[best];
                depth++;
            end
            else
            begin
                depth--;
                if (depth == 0)
                begin
                    push_status(ST_NO_PATH);
                    return;
                end
            end
        end
        for (int k = 0; k < depth; k++)
            expect_result(result_t'{trail[k], k == depth - 1, ST_OK});
    endfunction

    function automatic void predict_request(request_t r);
        case (r.command)
            CMD_LOAD:
            begin
                if (r.edge_from == r.edge_to)
                    return;
                if (edge_total >= MAX_EDGES)
                begin
                    push_status(ST_TABLE_FULL);
                    return;
                end
                if (r.edge_to == walk_finish)
                    finish_loaded = 1'b1;
                edge_src[edge_total]   = r.edge_from;
                edge_dst[edge_total]   = r.edge_to;
                edge_wt[edge_total]    = r.edge_weight;
                edge_taken[edge_total] = 1'b0;
                edge_total++;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < MAX_EDGES; i++)
                    edge_taken[i] = 1'b0;
                edge_total    = 0;
                finish_loaded = 1'b0;
            end
            CMD_RUN:
            begin
                runs_sent++;
                predict_walk();
            end
            default: ;
        endcase
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    task automatic send_request(logic [1:0] cmd, logic [7:0] src, logic [7:0] dst,
                                logic [15:0] wt);
        request_t r;
        r = '{cmd, src, dst, wt};
        idle_burst();
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        predict_request(r);
        requests_sent++;
    endtask

    // lets the block drain before a register write
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_path.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_START)
            walk_start = val;
        else
            walk_finish = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_path.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result vertex=%0d last=%0b status=%0d",
                             result.path_vertex, result.path_last, result.status);
            end
            else
            begin
                result_t want;
                want = expected_path.pop_front();
                if (result.path_vertex !== want.path_vertex ||
                    result.path_last !== want.path_last ||
                    result.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b/%0d got %0d/%0b/%0d",
                                 want.path_vertex, want.path_last, want.status,
                                 result.path_vertex, result.path_last, result.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no activity for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_quick_status();
        write_reg(REG_START, 8'd0);
        write_reg(REG_FINISH, 8'd0);
        send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
        write_reg(REG_START, 8'd5);
        write_reg(REG_FINISH, 8'd255);
        send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
        // unused command code
        send_request(2'd3, 8'd255, 8'd0, 16'hffff);
        send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
    endtask

    task automatic test_greedy_walk();
        send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD, 8'd5, 8'd9, 16'h0100);
        send_request(CMD_LOAD, 8'd5, 8'd20, 16'h0080);
        send_request(CMD_LOAD, 8'd5, 8'd30, 16'h0080);
        send_request(CMD_LOAD, 8'd20, 8'd255, 16'hffff);
        send_request(CMD_LOAD, 8'd9, 8'd9, 16'd0);
        send_request(CMD_LOAD, 8'd9, 8'd255, 16'd0);
        send_request(CMD_LOAD, 8'd30, 8'd0, 16'd7);
        // visit marks persist so later runs take other branches until none is left
        repeat (5) send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
    endtask

    task automatic test_dead_end();
        write_reg(REG_START, 8'd255);
        write_reg(REG_FINISH, 8'd0);
        send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD, 8'd7, 8'd0, 16'd1);
        send_request(CMD_LOAD, 8'd255, 8'd3, 16'd2);
        send_request(CMD_LOAD, 8'd3, 8'd255, 16'd3);
        send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
    endtask

    task automatic test_path_overflow();
        // a chain that fills the path stack exactly
        write_reg(REG_START, 8'd0);
        write_reg(REG_FINISH, 8'(MAX_PATH - 1));
        send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        for (int i = 0; i < MAX_PATH - 1; i++)
            send_request(CMD_LOAD, 8'(i), 8'(i + 1), 16'd0);
        send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
    endtask

    task automatic test_table_full();
        logic [7:0] a;
        write_reg(REG_START, 8'd0);
        write_reg(REG_FINISH, 8'd200);
        send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD, 8'd100, 8'd200, 16'd0);
        // chain one edge longer than the path stack, then random fill
        for (int i = 0; i < MAX_PATH; i++)
            send_request(CMD_LOAD, 8'(i), 8'(i + 1), 16'd0);
        for (int i = MAX_PATH + 1; i < MAX_EDGES; i++)
        begin
            a = 8'($urandom);
            send_request(CMD_LOAD, a, a ^ 8'($urandom_range(1, 255)), 16'($urandom));
        end
        send_request(CMD_RUN, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD, 8'd1, 8'd2, 16'd3);
        send_request(CMD_LOAD, 8'd4, 8'd4, 16'd3);
        send_request(CMD_LOAD, 8'd2, 8'd1, 16'd3);
        send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
    endtask

    task automatic test_random_graphs(int target);
        logic [7:0] pool [8];
        int npool;
        int nedges;
        int first;
        logic [7:0] a;
        logic [7:0] b;
        first = requests_sent;
        while (requests_sent - first < target)
        begin
            quiet = (requests_sent - first) > (target * 4) / 5;
            npool = $urandom_range(3, 8);
            for (int i = 0; i < npool; i++)
                pool[i] = 8'($urandom);
            write_reg(REG_START, pool[0]);
            write_reg(REG_FINISH, $urandom_range(0, 9) == 0 ? pool[0] : pool[npool-1]);
            send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
            nedges = $urandom_range(3, 14);
            for (int i = 0; i < nedges; i++)
            begin
                a = pool[$urandom_range(0, npool - 1)];
                b = pool[$urandom_range(0, npool - 1)];
                case ($urandom_range(0, 9))
                    0: send_request(2'd3, 8'($urandom), 8'($urandom), 16'($urandom));
                    1: send_request(CMD_LOAD, a, a, 16'($urandom));
                    2: send_request(CMD_LOAD, a, b, 16'($urandom_range(0, 3)));
                    default: send_request(CMD_LOAD, a, b, 16'($urandom));
                endcase
            end
            repeat ($urandom_range(1, 3))
                send_request(CMD_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        end
        quiet = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_START;
        cfg_data  = 8'd0;
        walk_start    = 8'd0;
        walk_finish   = 8'd0;
        edge_total    = 0;
        finish_loaded = 1'b0;
        for (int i = 0; i < MAX_EDGES; i++)
            edge_taken[i] = 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        results_seen  = 0;
        runs_sent     = 0;
        quiet         = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_quick_status();
        test_greedy_walk();
        test_dead_end();
        test_path_overflow();
        test_table_full();
        test_random_graphs(40);

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d requests, %0d searches and %0d results", requests_sent,
                 runs_sent, results_seen);
        $display("including status cases, tie breaks, path overflow and a full edge table");
        if (mismatches == 0 && expected_path.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d results never seen", mismatches,
                     expected_path.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
